### rtl/swhr_pkg.sv
`default_nettype none

package swhr_pkg;

  // Count, length and slot registers share one width
  localparam int CNT_W = 8;

  // Largest window; sizes the flag memory and caps the length
  localparam int MAX_WINDOW = 128;

  // Unsigned Q1.16 rate
  localparam int RATE_W = 17;

  // Width of the step counter of the bit-serial divider, one quotient bit per step
  localparam int DIV_CNT_W = $clog2(RATE_W + 1);

  // Frame total wraps at 32 bits
  localparam int TOTAL_W = 32;

  // Window length after reset
  localparam logic [CNT_W-1:0] DEFAULT_WINDOW = 8'd100;

  // State code counted as a hit
  localparam logic [7:0] HIT_CODE = 8'd1;

  // Item operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // Classified item as it waits in the queue
  typedef struct packed {
    logic op;
    logic hit;
  } queue_item_t;

  // Back-end sequencer
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } back_state_t;

endpackage

`default_nettype wire

### rtl/swhr_ram.sv
`default_nettype none

module swhr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/swhr_div.sv
`default_nettype none

module swhr_div
  import swhr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [CNT_W-1:0]  dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output      logic              busy,
  output      logic              done,
  output      logic [RATE_W-1:0] quot
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     den_r;
  logic [RATE_W-1:0]    quot_r;
  logic                 first_r;

  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;
  logic [CNT_W-1:0]     rem_step;

  // The dividend is hits * 2^16 with hits <= divisor: the first step
  // compares hits itself, each later step shifts in one zero bit
  assign trial    = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge       = trial >= {1'b0, den_r};
  assign diff     = trial - {1'b0, den_r};
  assign rem_step = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == DIV_CNT_W'(1));
  assign quot = quot_r;

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(RATE_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient, one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= dividend;
      den_r   <= divisor;
      first_r <= 1'b1;
      quot_r  <= '0;
    end else if (busy_r) begin
      rem_r   <= rem_step;
      first_r <= 1'b0;
      quot_r  <= {quot_r[RATE_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/swhr_front.sv
`default_nettype none

module swhr_front
  import swhr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_state_value,
  output      logic        q_valid,
  output      queue_item_t q_item,
  input  wire logic        q_pop
);

  queue_item_t     q_mem_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r;
  logic [QP_W-1:0] rd_ptr_r;
  logic [QP_W:0]   count_r;

  logic            push;
  queue_item_t     new_item;

  // Classify the incoming item
  assign new_item.op  = in_op;
  assign new_item.hit = (in_state_value == HIT_CODE);

  assign in_ready = (count_r != (QP_W + 1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // Store the item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QP_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QP_W'(1);
      end
      if (push && !q_pop) begin
        count_r <= count_r + (QP_W + 1)'(1);
      end else if (q_pop && !push) begin
        count_r <= count_r - (QP_W + 1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QP_W + 1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

### rtl/swhr_back.sv
`default_nettype none

module swhr_back
  import swhr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [CNT_W-1:0]   cfg_wr_data,
  input  wire logic               q_valid,
  input  wire queue_item_t        q_item,
  output      logic               q_pop,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [CNT_W-1:0]   out_hit_count,
  output      logic [RATE_W-1:0]  out_hit_rate,
  output      logic [CNT_W-1:0]   out_frames_held,
  output      logic [TOTAL_W-1:0] out_frames_total
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int EW = (AW > CNT_W) ? AW : CNT_W;

  // Map a requested length onto 1 .. MAX_WINDOW
  function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (32'(v) > MAX_WINDOW) return CNT_W'(MAX_WINDOW);
    return v;
  endfunction

  back_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   window_length_r;
  logic [CNT_W-1:0]   active_len_r, active_len_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   hits_r, hits_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               cur_hit_r;

  logic [EW-1:0]      fill_ext;
  logic [EW-1:0]      oldest_ext;
  logic [AW-1:0]      fill_slot;
  logic [AW-1:0]      oldest_slot;
  logic [CNT_W-1:0]   oldest_inc;

  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_waddr;
  logic               ram_wdata;
  logic [0:0]         ram_rdata;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [RATE_W-1:0]  div_quot;
  logic               out_load;

  // Slot addresses from the count registers
  assign fill_ext    = EW'(fill_r);
  assign oldest_ext  = EW'(oldest_r);
  assign fill_slot   = fill_ext[AW-1:0];
  assign oldest_slot = oldest_ext[AW-1:0];
  assign oldest_inc  = oldest_r + CNT_W'(1);

  // Sequence one item: pop, optional flag read, update or clear, divide, hand off
  always_comb begin
    state_nxt      = state_r;
    active_len_nxt = active_len_r;
    fill_nxt       = fill_r;
    oldest_nxt     = oldest_r;
    hits_nxt       = hits_r;
    total_nxt      = total_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = fill_slot;
    ram_wdata      = q_item.hit;
    div_start      = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_CLEAR) begin
            active_len_nxt = clamp_len(window_length_r);
            fill_nxt       = '0;
            oldest_nxt     = '0;
            hits_nxt       = '0;
            total_nxt      = '0;
            div_start      = 1'b1;
            state_nxt      = ST_DIV;
          end else if (fill_r >= active_len_r) begin
            ram_re    = 1'b1;
            state_nxt = ST_UPD;
          end else begin
            ram_we    = 1'b1;
            hits_nxt  = hits_r + CNT_W'(q_item.hit);
            fill_nxt  = fill_r + CNT_W'(1);
            total_nxt = total_r + TOTAL_W'(1);
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_UPD: begin
        // Overwrite the oldest flag and adjust the running count
        ram_we     = 1'b1;
        ram_waddr  = oldest_slot;
        ram_wdata  = cur_hit_r;
        hits_nxt   = hits_r - CNT_W'(ram_rdata) + CNT_W'(cur_hit_r);
        oldest_nxt = (oldest_inc >= active_len_r) ? '0 : oldest_inc;
        total_nxt  = total_r + TOTAL_W'(1);
        div_start  = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  // Control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      window_length_r <= DEFAULT_WINDOW;
      active_len_r    <= clamp_len(DEFAULT_WINDOW);
      fill_r          <= '0;
      oldest_r        <= '0;
      hits_r          <= '0;
      total_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_len_r <= active_len_nxt;
      fill_r       <= fill_nxt;
      oldest_r     <= oldest_nxt;
      hits_r       <= hits_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        window_length_r <= cfg_wr_data;
      end
    end
  end

  // Latch the hit flag of the item in flight
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_hit_r <= q_item.hit;
    end
  end

  // Load the result fields
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_count    <= hits_r;
      out_hit_rate     <= div_quot;
      out_frames_held  <= fill_r;
      out_frames_total <= total_r;
    end
  end

  swhr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WINDOW)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (oldest_slot),
    .rdata (ram_rdata)
  );

  swhr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (hits_nxt),
    .divisor  (active_len_nxt),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  a_hits_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r <= fill_r)
    else $error("hit count exceeds frames held");

  a_fill_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= active_len_r)
    else $error("frames held exceed window length");

  a_upd_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (fill_r == active_len_r) && (oldest_r < active_len_r))
    else $error("overwrite while window not full");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

endmodule

`default_nettype wire

### rtl/sliding_window_hit_rate_top.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_op, in_state_value
// out      output     out_valid / out_ready out_hit_count, out_hit_rate,
//                                           out_frames_held, out_frames_total
// cfg      input      cfg_wr_en             cfg_wr_data (window length)
//
// An accepted item waits in the queue until the back end pops it in ST_IDLE;
// once the window is full, ST_UPD reads and overwrites the oldest flag. The
// item then waits in ST_DIV for the 17-step bit-serial divider and in ST_HOLD
// until the result register is free; the back end takes one item at a time.
// A two-entry queue accepts items while the back end works, and a result
// register holds the last result while the back end takes the next item.
// Reset is synchronous and active low; window length returns to 100 and
// the flag memory needs no clearing pass.

`default_nettype none

module sliding_window_hit_rate_top
  import swhr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_op,
  input  wire logic [7:0]         in_state_value,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [CNT_W-1:0]   out_hit_count,
  output      logic [RATE_W-1:0]  out_hit_rate,
  output      logic [CNT_W-1:0]   out_frames_held,
  output      logic [TOTAL_W-1:0] out_frames_total,
  input  wire logic               cfg_wr_en,
  input  wire logic [CNT_W-1:0]   cfg_wr_data
);

  logic        q_valid;
  logic        q_pop;
  queue_item_t q_item;

  // Accept and classify items
  swhr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_state_value (in_state_value),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Update the window and compute the rate
  swhr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit_count    (out_hit_count),
    .out_hit_rate     (out_hit_rate),
    .out_frames_held  (out_frames_held),
    .out_frames_total (out_frames_total)
  );

endmodule

`default_nettype wire
